// ===== rtl/frpk_pkg.sv =====
`timescale 1ns / 1ps

package frpk_pkg;

    localparam int WORD_BITS      = 64;
    localparam int LIMB_BITS_DEF  = 60;
    // leftover count stays below LIMB_BITS, which is at most 63
    localparam int CNT_W          = 6;
    // leftover count plus one word, up to 126
    localparam int TOTAL_W        = 7;
    localparam int QUEUE_DEPTH    = 2;

    typedef struct packed {
        logic two_limbs;
        logic last;
    } frpk_ctl_t;

endpackage

// ===== rtl/frpk_if.sv =====
`timescale 1ns / 1ps

interface frpk_word_if;
    logic        valid;
    logic        ready;
    logic [63:0] word;
    logic        last_word;

    modport source (output valid, output word, output last_word, input ready);
    modport sink   (input valid, input word, input last_word, output ready);
endinterface

interface frpk_limb_if #(
    parameter int LIMB_BITS = 60
);
    logic                 valid;
    logic                 ready;
    logic [LIMB_BITS-1:0] limb;
    logic                 last_limb;

    modport source (output valid, output limb, output last_limb, input ready);
    modport sink   (input valid, input limb, input last_limb, output ready);
endinterface

// ===== rtl/frpk_front.sv =====
`timescale 1ns / 1ps

module frpk_front #(
    parameter int LIMB_BITS = frpk_pkg::LIMB_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    frpk_word_if.sink            words,
    input  logic                 full,
    output logic                 push,
    output logic [LIMB_BITS-1:0] limb0,
    output logic [LIMB_BITS-1:0] limb1,
    output frpk_pkg::frpk_ctl_t  ctl
);
    import frpk_pkg::*;

    localparam int VW = 3 * LIMB_BITS;

    logic [LIMB_BITS-2:0] leftover_bits_reg;
    logic [LIMB_BITS-2:0] leftover_bits_next;
    logic [CNT_W-1:0]     leftover_count_reg;
    logic [CNT_W-1:0]     leftover_count_next;
    logic [VW-1:0]        cat;
    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W-1:0]   rest;
    logic                 two_full;

    assign words.ready = !full;
    assign push        = words.valid && !full;

    always_comb
    begin
        // word sits above the leftover bits
        cat      = (VW'(words.word) << leftover_count_reg) | VW'(leftover_bits_reg);
        total    = TOTAL_W'(leftover_count_reg) + TOTAL_W'(WORD_BITS);
        two_full = total >= TOTAL_W'(2 * LIMB_BITS);
        rest     = two_full ? total - TOTAL_W'(2 * LIMB_BITS)
                            : total - TOTAL_W'(LIMB_BITS);

        limb0 = cat[LIMB_BITS-1:0];
        // second full limb, or the zero-padded tail on a last word
        limb1 = cat[2*LIMB_BITS-1:LIMB_BITS];

        ctl.last      = words.last_word;
        ctl.two_limbs = two_full || (words.last_word && rest != '0);

        leftover_bits_next  = leftover_bits_reg;
        leftover_count_next = leftover_count_reg;
        if (push)
        begin
            if (words.last_word)
            begin
                // start the next integer afresh; a third tail is dropped
                leftover_bits_next  = '0;
                leftover_count_next = '0;
            end
            else
            begin
                leftover_bits_next  = two_full ? cat[3*LIMB_BITS-2:2*LIMB_BITS]
                                               : cat[2*LIMB_BITS-2:LIMB_BITS];
                leftover_count_next = rest[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leftover_bits_reg  <= '0;
            leftover_count_reg <= '0;
        end
        else
        begin
            leftover_bits_reg  <= leftover_bits_next;
            leftover_count_reg <= leftover_count_next;
        end
    end

    a_count_below_limb: assert property (@(posedge clk) disable iff (!rst_n)
        leftover_count_reg < CNT_W'(LIMB_BITS))
        else $error("leftover count reached a full limb");

    a_leftover_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (leftover_bits_reg >> leftover_count_reg) == '0)
        else $error("leftover bits set above the count");

endmodule

// ===== rtl/frpk_queue.sv =====
`timescale 1ns / 1ps

module frpk_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = frpk_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

// ===== rtl/frpk_back.sv =====
`timescale 1ns / 1ps

module frpk_back #(
    parameter int LIMB_BITS = frpk_pkg::LIMB_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  logic [LIMB_BITS-1:0] limb0,
    input  logic [LIMB_BITS-1:0] limb1,
    input  frpk_pkg::frpk_ctl_t  ctl,
    output logic                 pop,
    frpk_limb_if.source          limbs
);
    import frpk_pkg::*;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [LIMB_BITS-1:0] out_limb_reg;
    logic [LIMB_BITS-1:0] out_limb_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    logic [LIMB_BITS-1:0] pend_limb_reg;
    logic [LIMB_BITS-1:0] pend_limb_next;
    logic                 pend_last_reg;
    logic                 pend_last_next;
    logic                 load;

    assign limbs.valid     = out_valid_reg;
    assign limbs.limb      = out_limb_reg;
    assign limbs.last_limb = out_last_reg;

    assign load = !out_valid_reg || limbs.ready;
    assign pop  = load && !pend_valid_reg && !empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_limb_next   = out_limb_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_limb_next  = pend_limb_reg;
        pend_last_next  = pend_last_reg;
        if (load)
        begin
            if (pend_valid_reg)
            begin
                // second limb of the entry goes out
                out_valid_next  = 1'b1;
                out_limb_next   = pend_limb_reg;
                out_last_next   = pend_last_reg;
                pend_valid_next = 1'b0;
            end
            else if (!empty)
            begin
                out_valid_next  = 1'b1;
                out_limb_next   = limb0;
                out_last_next   = ctl.last && !ctl.two_limbs;
                pend_valid_next = ctl.two_limbs;
                pend_limb_next  = limb1;
                pend_last_next  = ctl.last;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_limb_reg  <= out_limb_next;
        out_last_reg  <= out_last_next;
        pend_limb_reg <= pend_limb_next;
        pend_last_reg <= pend_last_next;
    end

    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second limb held with no first limb shown");

    a_last_closes_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> !pend_valid_reg)
        else $error("limb queued behind a final limb");

endmodule

// ===== rtl/full_radix_to_limb_repacker.sv =====
`timescale 1ns / 1ps

// Repacks an integer given as 64-bit words, least significant first, into
// LIMB_BITS-bit limbs, least significant first; the tail on the word marked
// last goes out zero-padded and flagged, and the block then starts afresh.
// A word yields one or two limbs; the output port sends one limb a cycle
// while the receiver is ready, so new words can be taken before the last
// word's limbs are out. The first limb of a word is registered in the queue
// and then in the output register; a two-entry queue between the word
// unpacker and the limb sender lets each side stall on its own.
module full_radix_to_limb_repacker #(
    parameter int LIMB_BITS = frpk_pkg::LIMB_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    frpk_word_if.sink   words,
    frpk_limb_if.source limbs
);
    import frpk_pkg::*;

    localparam int QW = 2 * LIMB_BITS + $bits(frpk_ctl_t);

    logic                 push;
    logic                 full;
    logic                 pop;
    logic                 empty;
    logic [LIMB_BITS-1:0] f_limb0;
    logic [LIMB_BITS-1:0] f_limb1;
    frpk_ctl_t            f_ctl;
    logic [QW-1:0]        q_din;
    logic [QW-1:0]        q_dout;
    logic [LIMB_BITS-1:0] b_limb0;
    logic [LIMB_BITS-1:0] b_limb1;
    frpk_ctl_t            b_ctl;

    assign q_din = {f_ctl, f_limb1, f_limb0};
    assign {b_ctl, b_limb1, b_limb0} = q_dout;

    frpk_front #(
        .LIMB_BITS (LIMB_BITS)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .words (words),
        .full  (full),
        .push  (push),
        .limb0 (f_limb0),
        .limb1 (f_limb1),
        .ctl   (f_ctl)
    );

    frpk_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (q_din),
        .full  (full),
        .pop   (pop),
        .dout  (q_dout),
        .empty (empty)
    );

    frpk_back #(
        .LIMB_BITS (LIMB_BITS)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (empty),
        .limb0 (b_limb0),
        .limb1 (b_limb1),
        .ctl   (b_ctl),
        .pop   (pop),
        .limbs (limbs)
    );

endmodule

// ===== tb/tb_full_radix_to_limb_repacker.sv =====
`timescale 1ns / 1ps

module tb_full_radix_to_limb_repacker;

    import frpk_pkg::*;

    localparam int LIMB_W       = LIMB_BITS_DEF;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 345;
    localparam int NUM_PHASES   = 4;
    localparam int SETTLE_TIME  = 20;

    typedef struct {
        logic [63:0] word;
        logic        last_word;
    } word_item_t;

    typedef struct {
        logic [LIMB_W-1:0] limb;
        logic              last_limb;
    } limb_item_t;

    logic clk;
    logic rst_n;

    frpk_word_if                         words_if ();
    frpk_limb_if #(.LIMB_BITS(LIMB_W))   limbs_if ();

    full_radix_to_limb_repacker #(.LIMB_BITS(LIMB_W)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .words (words_if),
        .limbs (limbs_if)
    );

    word_item_t        word_q[$];
    limb_item_t        limb_q[$];
    logic [LIMB_W-1:0] carry_bits;
    int                carry_cnt;
    int                err_cnt;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic              hold_go;
    int                hold_left;
    int                idle_cycles;

    // Append one word above the carried bits and queue the limbs it yields, at most two, padded tail included.
    task automatic repack_word(input logic [63:0] w, input logic last);
        logic [127:0] acc;
        int           total;
        int           n;
        limb_item_t   res[2];
        acc   = ({64'b0, w} << carry_cnt) | {{(128-LIMB_W){1'b0}}, carry_bits};
        total = carry_cnt + 64;
        n     = 0;
        while (total >= LIMB_W && n < 2)
        begin
            res[n].limb      = acc[LIMB_W-1:0];
            res[n].last_limb = 1'b0;
            n++;
            acc   = acc >> LIMB_W;
            total -= LIMB_W;
        end
        if (last)
        begin
            // no padded limb when nothing is left, or when two limbs already went out
            if (total > 0 && n < 2)
            begin
                res[n].limb      = acc[LIMB_W-1:0];
                res[n].last_limb = 1'b1;
                n++;
            end
            else
            begin
                res[n-1].last_limb = 1'b1;
            end
            carry_bits = '0;
            carry_cnt  = 0;
        end
        else
        begin
            carry_bits = acc[LIMB_W-1:0];
            carry_cnt  = total;
        end
        for (int i = 0; i < n; i++)
            limb_q.push_back(res[i]);
    endtask

    function automatic logic [63:0] random_word();
        int pick;
        pick = $urandom_range(15);
        case (pick)
            0:       return 64'h0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            3:       return ~(64'h1 << $urandom_range(63));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_word(input logic [63:0] w, input logic last);
        word_item_t it;
        it.word      = w;
        it.last_word = last;
        word_q.push_back(it);
    endtask

    // Queue one integer of the given length; the last word carries the flag.
    task automatic queue_integer(input int len);
        for (int i = 0; i < len; i++)
            queue_word(random_word(), i == len - 1);
    endtask

    task automatic wait_drained();
        while (word_q.size() != 0 || words_if.valid || limb_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Sender: offer the next pending word once the current one has transferred.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_if.valid     <= 1'b0;
            words_if.word      <= '0;
            words_if.last_word <= 1'b0;
        end
        else if (!words_if.valid || words_if.ready)
        begin
            if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                words_if.valid     <= 1'b1;
                words_if.word      <= word_q[0].word;
                words_if.last_word <= word_q[0].last_word;
                void'(word_q.pop_front());
            end
            else
            begin
                words_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limbs_if.ready <= 1'b0;
            hold_left      <= 0;
        end
        else if (hold_go)
        begin
            hold_go        <= 1'b0;
            hold_left      <= HOLD_CYCLES;
            limbs_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left      <= hold_left - 1;
            limbs_if.ready <= 1'b0;
        end
        else
        begin
            limbs_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predict on each word transfer, check each limb transfer.
    always @(posedge clk)
    begin
        limb_item_t exp_limb;
        if (rst_n)
        begin
            if (words_if.valid && words_if.ready)
                repack_word(words_if.word, words_if.last_word);
            if (limbs_if.valid && limbs_if.ready)
            begin
                if (limb_q.size() == 0)
                begin
                    $error("unexpected limb %h last_limb %b", limbs_if.limb,
                           limbs_if.last_limb);
                    err_cnt++;
                end
                else
                begin
                    exp_limb = limb_q.pop_front();
                    if (limbs_if.limb !== exp_limb.limb)
                    begin
                        $error("limb: expected %h, got %h", exp_limb.limb, limbs_if.limb);
                        err_cnt++;
                    end
                    if (limbs_if.last_limb !== exp_limb.last_limb)
                    begin
                        $error("last_limb: expected %b, got %b", exp_limb.last_limb,
                               limbs_if.last_limb);
                        err_cnt++;
                    end
                end
            end
        end
    end

    // Watchdog: abort when no transfer happens on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (words_if.valid && words_if.ready)
                   || (limbs_if.valid && limbs_if.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int send_pct[NUM_PHASES];
        int recv_pct[NUM_PHASES];
        int target;
        int len;
        int pick;
        send_pct = '{0, 48, 0, 14};
        recv_pct = '{0, 0, 48, 14};
        words_if.valid     = 1'b0;
        words_if.word      = '0;
        words_if.last_word = 1'b0;
        limbs_if.ready     = 1'b0;
        carry_bits         = '0;
        carry_cnt          = 0;
        err_cnt            = 0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        hold_go            = 1'b0;
        idle_cycles        = 0;
        rst_n              = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // single-word integers at the extremes
        queue_word(64'h0, 1'b1);
        queue_word('1, 1'b1);
        queue_word(64'h8000_0000_0000_0001, 1'b1);
        queue_word(64'h0FFF_FFFF_FFFF_FFFF, 1'b1);
        queue_word(64'hF000_0000_0000_0000, 1'b1);
        // two words
        queue_word('1, 1'b0);
        queue_word(64'h0, 1'b1);
        // fifteen words end exactly on a limb boundary: no padded limb
        for (int i = 0; i < 15; i++)
        begin
            case (i % 4)
                0:       queue_word('1, i == 14);
                1:       queue_word(64'h0, i == 14);
                2:       queue_word(64'h5555_5555_5555_5555, i == 14);
                default: queue_word(64'hAAAA_AAAA_AAAA_AAAA, i == 14);
            endcase
        end
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            // fill the block behind a long receiver hold-off
            if (p == 0)
                hold_go = 1'b1;
            target = 0;
            while (target < PHASE_ITEMS)
            begin
                pick = $urandom_range(19);
                if (pick < 2)
                    len = 1;
                else if (pick < 12)
                    len = $urandom_range(16, 2);
                else if (pick < 16)
                    len = $urandom_range(45, 17);
                else
                    len = 15 * $urandom_range(3, 1);
                queue_integer(len);
                target += len;
            end
            // wait until every queued word has gone in and every limb is out
            wait_drained();
        end

        repeat (SETTLE_TIME) @(negedge clk);
        if (err_cnt == 0 && limb_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
